// ----- rtl/iss_pkg.sv -----
// ----------------------------------------------------------------------------
// iss_pkg
// Shared types and field widths for the indexed sequence store.
// ----------------------------------------------------------------------------
package iss_pkg;

    localparam int FUNC_W   = 3;
    localparam int POS_W    = 6;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_APPEND = 3'd0,
        FUNC_INSERT = 3'd1,
        FUNC_REMOVE = 3'd2,
        FUNC_READ   = 3'd3,
        FUNC_CLEAR  = 3'd4
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic shift_up;
        logic shift_down;
        logic read;
    } t_cell_ctl;

endpackage

// ----- rtl/indexed_sequence_store.sv -----
// ----------------------------------------------------------------------------
// indexed_sequence_store
// Ordered store of signed values with append, insert, remove, read, clear.
// ----------------------------------------------------------------------------
// The store is a row of DEPTH cells, one entry each; insert shifts the entry
// at the position and all above it up one cell, remove shifts all entries
// above the position down one cell. Append, insert, remove, clear and unused
// codes finish when accepted. For a read, the addressed cell first loads its
// read tap, then the taps are merged into the result register; no request is
// taken in between. Each request gives exactly one result (value read, status,
// count after the request); the result waits in an output register, and the
// next request is taken in the same cycle that the result leaves. Entries hold
// nothing meaningful until written and need no clearing after reset.
module indexed_sequence_store #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [iss_pkg::FUNC_W-1:0]           i_func,
    input  logic [iss_pkg::POS_W-1:0]            i_position,
    input  logic signed [iss_pkg::VALUE_W-1:0]   i_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [iss_pkg::VALUE_W-1:0]   o_read_value,
    output logic [iss_pkg::STATUS_W-1:0]         o_status,
    output logic [iss_pkg::COUNT_W-1:0]          o_count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > iss_pkg::POS_W) ? CW : iss_pkg::POS_W;
    localparam int VX = (DATA_WIDTH > iss_pkg::VALUE_W) ? DATA_WIDTH : iss_pkg::VALUE_W;

    iss_pkg::t_cell_ctl ctl;

    logic [PW-1:0]                 index;
    logic [VX-1:0]                 value_x;
    logic [DATA_WIDTH-1:0]         cell_value;
    logic [DATA_WIDTH-1:0]         w_data [DEPTH];
    logic [DATA_WIDTH-1:0]         w_tap  [DEPTH];
    logic [DATA_WIDTH-1:0]         tap_or;
    logic [VX-1:0]                 rd_x;
    logic [iss_pkg::VALUE_W-1:0]   read_data;
    logic [iss_pkg::VALUE_W-1:0]   read_value;

    assign value_x    = VX'($unsigned(i_value));
    assign cell_value = value_x[DATA_WIDTH-1:0];

    iss_ctrl #(
        .DEPTH (DEPTH),
        .CW    (CW),
        .PW    (PW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_position   (i_position),
        .o_ctl        (ctl),
        .o_index      (index),
        .i_read_data  (read_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_read_value (read_value),
        .o_status     (o_status),
        .o_count      (o_count)
    );

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] left;
        logic [DATA_WIDTH-1:0] right;

        if (g == 0) begin : g_first
            assign left = '0;
        end else begin : g_left
            assign left = w_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right = '0;
        end else begin : g_right
            assign right = w_data[g+1];
        end

        iss_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX_W      (PW),
            .IDX        (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_index (index),
            .i_value (cell_value),
            .i_left  (left),
            .i_right (right),
            .o_data  (w_data[g]),
            .o_tap   (w_tap[g])
        );
    end

    // at most one tap is nonzero
    always_comb begin
        tap_or = '0;
        for (int k = 0; k < DEPTH; k++) begin
            tap_or = tap_or | w_tap[k];
        end
    end

    assign rd_x         = VX'(tap_or);
    assign read_data    = rd_x[iss_pkg::VALUE_W-1:0];
    assign o_read_value = $signed(read_value);

endmodule

// ----- rtl/iss_cell.sv -----
// ----------------------------------------------------------------------------
// iss_cell
// One entry of the store: holds a word, takes its left neighbor on insert,
// its right neighbor on remove, and drives a registered read tap.
// ----------------------------------------------------------------------------
module iss_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int IDX_W      = 7,
    parameter int IDX        = 0
) (
    input  logic                  i_clk,
    input  iss_pkg::t_cell_ctl    i_ctl,
    input  logic [IDX_W-1:0]      i_index,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic [DATA_WIDTH-1:0] o_tap
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic [DATA_WIDTH-1:0] r_tap;
    logic [DATA_WIDTH-1:0] n_tap;
    logic                  hit;
    logic                  above;

    assign hit   = (i_index == MY_IDX);
    assign above = (MY_IDX > i_index);

    always_comb begin
        n_data = r_data;
        if (i_ctl.shift_up) begin
            if (hit) begin
                n_data = i_value;
            end else if (above) begin
                n_data = i_left;
            end
        end else if (i_ctl.shift_down) begin
            if (hit || above) begin
                n_data = i_right;
            end
        end
    end

    assign n_tap = (i_ctl.read && hit) ? r_data : '0;

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_tap  <= n_tap;
    end

    assign o_data = r_data;
    assign o_tap  = r_tap;

endmodule

// ----- rtl/iss_ctrl.sv -----
// ----------------------------------------------------------------------------
// iss_ctrl
// Command decode, entry count, request handshake and result register.
// ----------------------------------------------------------------------------
module iss_ctrl #(
    parameter int DEPTH = 64,
    parameter int CW    = 7,
    parameter int PW    = 7
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [iss_pkg::FUNC_W-1:0]      i_func,
    input  logic [iss_pkg::POS_W-1:0]       i_position,
    output iss_pkg::t_cell_ctl              o_ctl,
    output logic [PW-1:0]                   o_index,
    input  logic [iss_pkg::VALUE_W-1:0]     i_read_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [iss_pkg::VALUE_W-1:0]     o_read_value,
    output logic [iss_pkg::STATUS_W-1:0]    o_status,
    output logic [iss_pkg::COUNT_W-1:0]     o_count
);

    localparam int XW = (CW > iss_pkg::COUNT_W) ? CW : iss_pkg::COUNT_W;

    iss_pkg::t_state  r_state;
    iss_pkg::t_state  n_state;
    iss_pkg::t_status st;
    iss_pkg::t_cell_ctl ctl;

    logic [CW-1:0]  r_count;
    logic [CW-1:0]  n_count;
    logic [PW-1:0]  pos_ext;
    logic [PW-1:0]  cnt_ext;
    logic [XW-1:0]  cnt_x;
    logic           accept;
    logic           is_read;
    logic           full;
    logic           empty;
    logic           out_taken;

    logic                            r_out_valid;
    logic [iss_pkg::VALUE_W-1:0]     r_read_value;
    logic [iss_pkg::STATUS_W-1:0]    r_status;
    logic [iss_pkg::COUNT_W-1:0]     r_count_out;

    assign out_taken = r_out_valid && !i_out_stall;
    assign accept    = i_in_valid && !o_in_stall;
    assign is_read   = (iss_pkg::t_func'(i_func) == iss_pkg::FUNC_READ);
    assign pos_ext   = PW'(i_position);
    assign cnt_ext   = PW'(r_count);
    assign full      = (r_count == CW'(DEPTH));
    assign empty     = (r_count == '0);

    // command decode
    always_comb begin
        st      = iss_pkg::ST_OK;
        ctl     = '0;
        n_count = r_count;
        o_index = pos_ext;
        unique case (iss_pkg::t_func'(i_func))
            iss_pkg::FUNC_APPEND: begin
                o_index = cnt_ext;
                if (full) begin
                    st = iss_pkg::ST_FULL;
                end else begin
                    ctl.shift_up = 1'b1;
                    n_count      = CW'(r_count + CW'(1));
                end
            end
            iss_pkg::FUNC_INSERT: begin
                if (full) begin
                    st = iss_pkg::ST_FULL;
                end else if (pos_ext > cnt_ext) begin
                    st = iss_pkg::ST_RANGE;
                end else begin
                    ctl.shift_up = 1'b1;
                    n_count      = CW'(r_count + CW'(1));
                end
            end
            iss_pkg::FUNC_REMOVE: begin
                if (empty) begin
                    st = iss_pkg::ST_EMPTY;
                end else if (pos_ext >= cnt_ext) begin
                    st = iss_pkg::ST_RANGE;
                end else begin
                    ctl.shift_down = 1'b1;
                    n_count        = CW'(r_count - CW'(1));
                end
            end
            iss_pkg::FUNC_READ: begin
                if (empty) begin
                    st = iss_pkg::ST_EMPTY;
                end else if (pos_ext >= cnt_ext) begin
                    st = iss_pkg::ST_RANGE;
                end else begin
                    ctl.read = 1'b1;
                end
            end
            iss_pkg::FUNC_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    assign o_ctl = accept ? ctl : '0;
    assign cnt_x = XW'(n_count);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            iss_pkg::S_IDLE: begin
                if (accept && is_read) begin
                    n_state = iss_pkg::S_READ;
                end
            end
            iss_pkg::S_READ: begin
                n_state = iss_pkg::S_IDLE;
            end
            default: begin
                n_state = iss_pkg::S_IDLE;
            end
        endcase
    end

    // outputs of the state machine
    always_comb begin
        unique case (r_state)
            iss_pkg::S_IDLE: o_in_stall = r_out_valid && i_out_stall;
            iss_pkg::S_READ: o_in_stall = 1'b1;
            default:         o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= iss_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_count <= n_count;
            end
            // a read shows its result only from the read state, once the taps are loaded
            if ((accept && !is_read) || (r_state == iss_pkg::S_READ)) begin
                r_out_valid <= 1'b1;
            end else if (out_taken) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status     <= st;
            r_count_out  <= cnt_x[iss_pkg::COUNT_W-1:0];
            r_read_value <= '0;
        end else if (r_state == iss_pkg::S_READ) begin
            r_read_value <= i_read_data;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_read_value;
    assign o_status     = r_status;
    assign o_count      = r_count_out;

endmodule

// ----- tb/sv/indexed_sequence_store_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_sequence_store_checker
// Watches both channels of the indexed sequence store, keeps its own copy of
// the stored sequence, predicts the result of every accepted request and
// compares each accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module indexed_sequence_store_checker
    import iss_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic [FUNC_W-1:0]          i_func,
    input  logic [POS_W-1:0]           i_position,
    input  logic signed [VALUE_W-1:0]  i_value,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic signed [VALUE_W-1:0]  i_read_value,
    input  logic [STATUS_W-1:0]        i_status,
    input  logic [COUNT_W-1:0]         i_count,
    output int                         o_failures,
    output int                         o_pending
);

    localparam int PRINT_CAP = 40;

    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        t_status            status;
        logic [COUNT_W-1:0] count;
    } t_outcome;

    logic [VALUE_W-1:0] held_values [DEPTH];
    int                 held_count = 0;
    t_outcome           pending_outcomes [$];
    int                 mismatch_count = 0;
    int                 pending_level = 0;

    assign o_failures = mismatch_count;
    assign o_pending  = pending_level;

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_CAP) begin
            $display("%0t ns: mismatch: %s", $time, what);
        end
        mismatch_count++;
    endtask

    // updates the shadow sequence and returns what the block must answer
    function automatic t_outcome apply_command(input logic [FUNC_W-1:0] func,
                                               input logic [POS_W-1:0] pos,
                                               input logic [VALUE_W-1:0] value);
        t_outcome res;
        int       k;
        res.read_value = '0;
        res.status     = ST_OK;
        case (func)
            FUNC_APPEND: begin
                if (held_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    held_values[held_count] = value;
                    held_count++;
                end
            end
            FUNC_INSERT: begin
                // full wins over a bad position
                if (held_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else if (int'(pos) > held_count) begin
                    res.status = ST_RANGE;
                end else begin
                    for (k = held_count; k > int'(pos); k--) begin
                        held_values[k] = held_values[k-1];
                    end
                    held_values[pos] = value;
                    held_count++;
                end
            end
            FUNC_REMOVE: begin
                if (held_count == 0) begin
                    res.status = ST_EMPTY;
                end else if (int'(pos) >= held_count) begin
                    res.status = ST_RANGE;
                end else begin
                    for (k = int'(pos); k < held_count - 1; k++) begin
                        held_values[k] = held_values[k+1];
                    end
                    held_count--;
                end
            end
            FUNC_READ: begin
                if (held_count == 0) begin
                    res.status = ST_EMPTY;
                end else if (int'(pos) >= held_count) begin
                    res.status = ST_RANGE;
                end else begin
                    res.read_value = held_values[pos];
                end
            end
            FUNC_CLEAR: begin
                held_count = 0;
            end
            default: begin
            end
        endcase
        res.count = COUNT_W'(held_count);
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_outcome want;
        if (i_rst_n) begin
            // a result leaving now belongs to an earlier request
            if (i_out_valid && !i_out_stall) begin
                if (pending_outcomes.size() == 0) begin
                    report_mismatch($sformatf("unexpected result value %h status %0d count %0d",
                                              i_read_value, i_status, i_count));
                end else begin
                    want = pending_outcomes.pop_front();
                    if (i_read_value !== want.read_value) begin
                        report_mismatch($sformatf("read_value %h, want %h",
                                                  i_read_value, want.read_value));
                    end
                    if (i_status !== want.status) begin
                        report_mismatch($sformatf("status %0d, want %s",
                                                  i_status, want.status.name()));
                    end
                    if (i_count !== want.count) begin
                        report_mismatch($sformatf("count %0d, want %0d",
                                                  i_count, want.count));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                pending_outcomes.push_back(apply_command(i_func, i_position, i_value));
            end
        end
        pending_level <= pending_outcomes.size();
    end

endmodule

// ----- tb/sv/indexed_sequence_store_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_sequence_store_tb
// Drives directed and shaped random requests into the indexed sequence store
// with bursty sending and patterned result stalls; the checker beside the
// block predicts and compares, and this module gives the verdict.
// ----------------------------------------------------------------------------
module indexed_sequence_store_tb;
    import iss_pkg::*;

    localparam int DEPTH          = 64;
    localparam int REQUEST_TARGET = 1950;
    localparam int CYCLE_LIMIT    = 500000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int CALM_EVERY     = 300;
    localparam int POS_MAX        = (1 << POS_W) - 1;

    // codes the block treats as no operation
    localparam logic [FUNC_W-1:0] FUNC_SPARE_LO  = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_MID = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_HI  = 3'd7;

    typedef enum logic [1:0] {EP_GROW, EP_SHRINK, EP_MIXED, EP_NOISE} t_episode;
    typedef enum logic [2:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_COMB, RX_HOLD} t_rx_mode;

    logic                       i_clk        = 1'b0;
    logic                       i_rst_n      = 1'b0;
    logic                       i_in_valid   = 1'b0;
    logic                       o_in_stall;
    logic [FUNC_W-1:0]          i_func       = '0;
    logic [POS_W-1:0]           i_position   = '0;
    logic signed [VALUE_W-1:0]  i_value      = '0;
    logic                       o_out_valid;
    logic                       i_out_stall  = 1'b0;
    logic signed [VALUE_W-1:0]  o_read_value;
    logic [STATUS_W-1:0]        o_status;
    logic [COUNT_W-1:0]         o_count;

    int       failures;
    int       pending;
    int       cycle_count   = 0;
    int       requests_sent = 0;
    int       fill_level    = 0;
    int       burst_left    = 0;
    t_rx_mode rx_mode       = RX_FREE;
    int       rx_ticks      = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    indexed_sequence_store #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (VALUE_W)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_position   (i_position),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_read_value (o_read_value),
        .o_status     (o_status),
        .o_count      (o_count)
    );

    indexed_sequence_store_checker #(
        .DEPTH (DEPTH)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_position   (i_position),
        .i_value      (i_value),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_read_value (o_read_value),
        .i_status     (o_status),
        .i_count      (o_count),
        .o_failures   (failures),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("indexed_sequence_store_tb failed");
            $finish;
        end
    end

    // result side stalls in randomly chosen modes
    always @(negedge i_clk) begin
        if (rx_ticks == 0) begin
            rx_mode  = t_rx_mode'($urandom_range(RX_FREE, RX_HOLD));
            rx_ticks = $urandom_range(20, 120);
        end else begin
            rx_ticks--;
        end
        case (rx_mode)
            RX_FREE:  i_out_stall <= 1'b0;
            RX_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
            RX_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
            RX_COMB:  i_out_stall <= (rx_ticks % 5 < 2);
            default:  i_out_stall <= (rx_ticks % 16 < 12);
        endcase
    end

    // called at a falling edge; returns at the falling edge after acceptance, or later after an idle gap or a drain
    task automatic send_req(input logic [FUNC_W-1:0] func,
                            input logic [POS_W-1:0] pos,
                            input logic [VALUE_W-1:0] value);
        int gap;
        i_in_valid <= 1'b1;
        i_func     <= func;
        i_position <= pos;
        i_value    <= value;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        requests_sent++;
        // rough level, only used to aim positions
        case (func)
            FUNC_APPEND, FUNC_INSERT: if (fill_level < DEPTH) fill_level++;
            FUNC_REMOVE:              if (fill_level > 0) fill_level--;
            FUNC_CLEAR:               fill_level = 0;
            default: begin
            end
        endcase
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        if (requests_sent % CALM_EVERY == 0) begin
            i_in_valid <= 1'b0;
            do @(negedge i_clk); while (pending != 0);
        end
    endtask

    task automatic issue_shaped(input t_episode ep);
        int                 roll;
        int                 top_pos;
        logic [FUNC_W-1:0]  func;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] value;
        roll  = $urandom_range(0, 99);
        value = $urandom;
        case (ep)
            EP_GROW:   func = (roll < 55) ? FUNC_APPEND :
                              (roll < 90) ? FUNC_INSERT : FUNC_READ;
            EP_SHRINK: func = (roll < 65) ? FUNC_REMOVE :
                              (roll < 90) ? FUNC_READ : FUNC_INSERT;
            EP_MIXED:  func = (roll < 20) ? FUNC_APPEND :
                              (roll < 40) ? FUNC_INSERT :
                              (roll < 62) ? FUNC_REMOVE :
                              (roll < 97) ? FUNC_READ : FUNC_CLEAR;
            default:   func = FUNC_W'($urandom_range(FUNC_APPEND, FUNC_SPARE_HI));
        endcase
        top_pos = (func == FUNC_INSERT) ? fill_level : fill_level - 1;
        if (ep == EP_NOISE || top_pos < 0 || $urandom_range(0, 9) == 0) begin
            pos = POS_W'($urandom_range(0, POS_MAX));
        end else begin
            pos = POS_W'($urandom_range(0, (top_pos > POS_MAX) ? POS_MAX : top_pos));
        end
        send_req(func, pos, value);
    endtask

    initial begin
        int       stop_at;
        int       len;
        int       pick;
        t_episode ep;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty store, range errors, extremes of the value and position
        send_req(FUNC_READ,   '0,      '0);
        send_req(FUNC_REMOVE, '0,      '1);
        send_req(FUNC_INSERT, 6'd1,    32'h1234_5678);
        send_req(FUNC_INSERT, '0,      32'h8000_0000);
        send_req(FUNC_APPEND, POS_MAX, 32'h7fff_ffff);
        send_req(FUNC_APPEND, '0,      '0);
        send_req(FUNC_APPEND, '0,      '1);
        send_req(FUNC_READ,   6'd0,    '0);
        send_req(FUNC_READ,   6'd3,    '1);
        send_req(FUNC_READ,   6'd4,    '0);
        send_req(FUNC_REMOVE, POS_MAX, '0);
        send_req(FUNC_INSERT, 6'd4,    32'h5555_5555);
        send_req(FUNC_INSERT, 6'd2,    32'haaaa_aaaa);
        send_req(FUNC_INSERT, 6'd9,    32'h0f0f_0f0f);
        send_req(FUNC_READ,   6'd2,    '0);
        send_req(FUNC_REMOVE, 6'd0,    '0);
        send_req(FUNC_READ,   6'd0,    '0);
        send_req(FUNC_REMOVE, 6'd4,    '0);
        send_req(FUNC_READ,   6'd4,    '0);
        send_req(FUNC_SPARE_LO,  POS_MAX, '1);
        send_req(FUNC_SPARE_MID, 6'd1,    32'h0000_0001);
        send_req(FUNC_SPARE_HI,  6'd2,    '0);
        send_req(FUNC_CLEAR,  POS_MAX, '1);
        send_req(FUNC_READ,   '0,      '0);

        stop_at = requests_sent + REQUEST_TARGET;

        // start by filling the store past full
        repeat (90) issue_shaped(EP_GROW);

        while (requests_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            ep   = (pick < 35) ? EP_GROW :
                   (pick < 65) ? EP_SHRINK :
                   (pick < 93) ? EP_MIXED : EP_NOISE;
            len  = $urandom_range(5, 80);
            repeat (len) begin
                if (requests_sent < stop_at) begin
                    issue_shaped(ep);
                end
            end
        end

        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (failures == 0) begin
            $display("indexed_sequence_store_tb passed");
        end else begin
            $display("indexed_sequence_store_tb failed");
        end
        $finish;
    end

endmodule
